@@ hdl/unsigned_to_ascii_digits_defines.svh @@
// assertion macros for the unsigned to ascii digits block
// used by unsigned_to_ascii_digits.sv; needs a clk and rst_n in scope
`ifndef UNSIGNED_TO_ASCII_DIGITS_DEFINES_SVH
`define UNSIGNED_TO_ASCII_DIGITS_DEFINES_SVH

// checked only out of reset
`define UAD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define UAD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/uad_pkg.sv @@
// shared types, codes and helpers for the unsigned to ascii digits block
// no dependencies
package uad_pkg;

  localparam int NumDigits = 10;
  localparam int NumHexDigits = 8;
  localparam int BinWidth = 32;
  localparam int DigitWidth = 4;
  localparam int BufWidth = NumDigits * DigitWidth;

  localparam logic [1:0] CMD_DEC = 2'd0;
  localparam logic [1:0] CMD_HEX_LOWER = 2'd1;
  localparam logic [1:0] CMD_HEX_UPPER = 2'd2;
  localparam logic [1:0] CMD_PERCENT = 2'd3;

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_PERCENT = 8'h25;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
    logic [3:0] char_count;
  } out_item_t;

  // ascii code of one digit
  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] base;
    base = upper ? CHAR_UPPER_A : CHAR_LOWER_A;
    if (d < 4'd10) begin
      digit_char = CHAR_ZERO + {4'h0, d};
    end else begin
      digit_char = base + {4'h0, d} - 8'd10;
    end
  endfunction

endpackage

@@ hdl/unsigned_to_ascii_digits.sv @@
// unsigned to ascii digits top level: shift-add-3 converter and digit emitter
// depends on uad_pkg and unsigned_to_ascii_digits_defines.svh
//
// Converts a 32-bit unsigned value to ascii characters, most significant
// first, in decimal, lower-case hex or upper-case hex, or emits a single '%'.
// One item at a time: in_ready is high only while the block is idle. A
// decimal item runs through one shared shift-add-3 unit (one binary bit
// per cycle into a 10-digit bcd register); hex items skip this. Then leading
// zeros are dropped, one per cycle, keeping at least one digit, and the
// characters are delivered one per cycle while out_ready is high. The last
// character carries last and the run length in char_count.
`include "unsigned_to_ascii_digits_defines.svh"

module unsigned_to_ascii_digits (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  uad_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output uad_pkg::out_item_t out_data
);

  uad_pkg::state_t state_r, state_nxt;
  logic [uad_pkg::BufWidth-1:0] digits_r, digits_nxt;
  logic [uad_pkg::BinWidth-1:0] bin_r, bin_nxt;
  logic [4:0] step_r, step_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic [3:0] total_r, total_nxt;
  logic [1:0] cmd_r, cmd_nxt;

  logic [uad_pkg::BufWidth-1:0] adjusted;
  logic [3:0] top_digit;

  // add 3 to every bcd digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < uad_pkg::NumDigits; i++) begin
      if (digits_r[i*4 +: 4] >= 4'd5) begin
        adjusted[i*4 +: 4] = digits_r[i*4 +: 4] + 4'd3;
      end else begin
        adjusted[i*4 +: 4] = digits_r[i*4 +: 4];
      end
    end
  end

  assign top_digit = digits_r[uad_pkg::BufWidth-1 -: 4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= uad_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    digits_r <= digits_nxt;
    bin_r    <= bin_nxt;
    step_r   <= step_nxt;
    cnt_r    <= cnt_nxt;
    total_r  <= total_nxt;
    cmd_r    <= cmd_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    digits_nxt = digits_r;
    bin_nxt    = bin_r;
    step_nxt   = step_r;
    cnt_nxt    = cnt_r;
    total_nxt  = total_r;
    cmd_nxt    = cmd_r;
    in_ready   = 1'b0;
    out_valid  = 1'b0;

    unique case (state_r)
      uad_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd_nxt = in_data.command;
          unique case (in_data.command)
            uad_pkg::CMD_DEC: begin
              digits_nxt = '0;
              bin_nxt    = in_data.value;
              step_nxt   = '0;
              cnt_nxt    = 4'(uad_pkg::NumDigits);
              state_nxt  = uad_pkg::ST_CONV;
            end
            uad_pkg::CMD_HEX_LOWER, uad_pkg::CMD_HEX_UPPER: begin
              digits_nxt = {in_data.value, 8'h00};
              cnt_nxt    = 4'(uad_pkg::NumHexDigits);
              state_nxt  = uad_pkg::ST_SKIP;
            end
            default: begin
              cnt_nxt   = 4'd1;
              total_nxt = 4'd1;
              state_nxt = uad_pkg::ST_EMIT;
            end
          endcase
        end
      end
      uad_pkg::ST_CONV: begin
        digits_nxt = {adjusted[uad_pkg::BufWidth-2:0], bin_r[uad_pkg::BinWidth-1]};
        bin_nxt    = {bin_r[uad_pkg::BinWidth-2:0], 1'b0};
        step_nxt   = step_r + 5'd1;
        if (step_r == 5'(uad_pkg::BinWidth - 1)) begin
          state_nxt = uad_pkg::ST_SKIP;
        end
      end
      uad_pkg::ST_SKIP: begin
        // drop one leading zero a cycle, keeping at least one digit
        if (top_digit == 4'd0 && cnt_r > 4'd1) begin
          digits_nxt = {digits_r[uad_pkg::BufWidth-5:0], 4'h0};
          cnt_nxt    = cnt_r - 4'd1;
        end else begin
          total_nxt = cnt_r;
          state_nxt = uad_pkg::ST_EMIT;
        end
      end
      uad_pkg::ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          digits_nxt = {digits_r[uad_pkg::BufWidth-5:0], 4'h0};
          cnt_nxt    = cnt_r - 4'd1;
          if (cnt_r == 4'd1) begin
            state_nxt = uad_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = uad_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_r == uad_pkg::CMD_PERCENT) begin
      out_data.character = uad_pkg::CHAR_PERCENT;
    end else begin
      out_data.character = uad_pkg::digit_char(top_digit, cmd_r == uad_pkg::CMD_HEX_UPPER);
    end
    out_data.last       = (cnt_r == 4'd1);
    out_data.char_count = (cnt_r == 4'd1) ? total_r : 4'd0;
  end

  `UAD_ASSERT(a_cnt_in_run, out_valid |-> (cnt_r >= 4'd1 && cnt_r <= total_r), "remaining count out of run")
  `UAD_ASSERT(a_conv_ends, (state_r == uad_pkg::ST_CONV && step_r == 5'd31) |=> state_r == uad_pkg::ST_SKIP, "conversion did not end after 32 steps")
  `UAD_ASSERT(a_last_frees, (out_valid && out_ready && out_data.last) |=> in_ready, "block not idle after last item")
  `UAD_ASSERT(a_bcd_digit, (out_valid && cmd_r == uad_pkg::CMD_DEC) |-> top_digit <= 4'd9, "decimal digit above nine")
  `UAD_ASSERT_ALWAYS(a_one_side, !(in_ready && out_valid), "input and output active together")

endmodule

@@ tb/sv/ascii_run_checker.sv @@
// checker for unsigned_to_ascii_digits: predicts the character run of each
// accepted item and compares it with what the block delivers; needs uad_pkg
`timescale 1ns / 1ps

module ascii_run_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  uad_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  uad_pkg::out_item_t out_data,
  output int                 mismatch_count,
  output int                 chars_outstanding
);

  uad_pkg::out_item_t expected_chars[$];

  initial begin
    mismatch_count = 0;
    chars_outstanding = 0;
  end

  // digits are found least significant first, then queued in reverse
  function automatic void queue_ascii_run(input logic [1:0] cmd, input logic [31:0] value);
    logic [7:0]         digits_rev[0:9];
    logic [31:0]        rest;
    logic [3:0]         digit;
    int                 radix;
    int                 n;
    string              digit_table;
    uad_pkg::out_item_t ch;
    n = 0;
    if (cmd == uad_pkg::CMD_PERCENT) begin
      digits_rev[0] = "%";
      n = 1;
    end else begin
      radix = (cmd == uad_pkg::CMD_DEC) ? 10 : 16;
      digit_table = (cmd == uad_pkg::CMD_HEX_UPPER) ? "0123456789ABCDEF"
                                                     : "0123456789abcdef";
      rest = value;
      do begin
        digit = 4'(rest % radix);
        digits_rev[n] = digit_table[digit];
        rest = rest / radix;
        n++;
      end while (rest != 0 && n < 10);
    end
    for (int k = 0; k < n; k++) begin
      ch.character = digits_rev[n - 1 - k];
      ch.last = (k == n - 1);
      ch.char_count = (k == n - 1) ? 4'(n) : 4'd0;
      expected_chars.push_back(ch);
    end
  endfunction

  always @(posedge clk) begin
    uad_pkg::out_item_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_chars.size() == 0) begin
          $display("%0t: unexpected character %h last %b count %0d", $time,
                   out_data.character, out_data.last, out_data.char_count);
          mismatch_count++;
        end else begin
          want = expected_chars.pop_front();
          if (out_data.character !== want.character) begin
            $display("%0t: character expected %h got %h", $time, want.character,
                     out_data.character);
            mismatch_count++;
          end
          if (out_data.last !== want.last) begin
            $display("%0t: last expected %b got %b", $time, want.last, out_data.last);
            mismatch_count++;
          end
          if (out_data.char_count !== want.char_count) begin
            $display("%0t: char_count expected %0d got %0d", $time, want.char_count,
                     out_data.char_count);
            mismatch_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        queue_ascii_run(in_data.command, in_data.value);
      end
    end
    chars_outstanding <= expected_chars.size();
  end

endmodule

@@ tb/sv/tb_unsigned_to_ascii_digits.sv @@
// testbench top for unsigned_to_ascii_digits: directed and random items under
// varying back-pressure; checking is done by ascii_run_checker, needs uad_pkg
`timescale 1ns / 1ps

module tb_unsigned_to_ascii_digits;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  uad_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  uad_pkg::out_item_t out_data;
  int                 mismatch_count;
  int                 chars_outstanding;
  int                 gap_pct = 0;
  int                 stall_pct = 0;

  always #10 clk = ~clk;

  unsigned_to_ascii_digits u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  ascii_run_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data          (in_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_data         (out_data),
    .mismatch_count   (mismatch_count),
    .chars_outstanding(chars_outstanding)
  );

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // called at a rising edge; returns at the edge where the item is taken
  task automatic send_item(input logic [1:0] cmd, input logic [31:0] value);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data.command <= cmd;
    in_data.value <= value;
    do @(posedge clk); while (!in_ready);
  endtask

  // values near digit-count boundaries show up far more often than uniform
  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0: v = $urandom;
      1: v = $urandom_range(0, 20);
      2: v = $urandom >> $urandom_range(0, 31);
      3: begin
        v = 32'd1;
        repeat ($urandom_range(0, 9)) v = v * 10;
        v = v - $urandom_range(0, 1);
      end
      4: v = (32'd1 << (4 * $urandom_range(0, 7))) - $urandom_range(0, 1);
      default: v = 32'hFFFF_FFFF - $urandom_range(0, 3);
    endcase
    return v;
  endfunction

  task automatic send_random(input int count);
    repeat (count) send_item(2'($urandom_range(0, 3)), pick_value());
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    gap_pct = 20;
    stall_pct = 53;
    send_item(uad_pkg::CMD_DEC, 32'd0);
    send_item(uad_pkg::CMD_HEX_LOWER, 32'd0);
    send_item(uad_pkg::CMD_HEX_UPPER, 32'd0);
    send_item(uad_pkg::CMD_DEC, 32'hFFFF_FFFF);
    send_item(uad_pkg::CMD_HEX_LOWER, 32'hFFFF_FFFF);
    send_item(uad_pkg::CMD_HEX_UPPER, 32'hFFFF_FFFF);
    send_item(uad_pkg::CMD_PERCENT, 32'd0);
    send_item(uad_pkg::CMD_PERCENT, 32'hFFFF_FFFF);
    send_item(uad_pkg::CMD_PERCENT, 32'h1234_5678);
    send_item(uad_pkg::CMD_DEC, 32'd1);
    send_item(uad_pkg::CMD_DEC, 32'd9);
    send_item(uad_pkg::CMD_DEC, 32'd10);
    send_item(uad_pkg::CMD_DEC, 32'd99);
    send_item(uad_pkg::CMD_DEC, 32'd100);
    send_item(uad_pkg::CMD_DEC, 32'd999_999_999);
    send_item(uad_pkg::CMD_DEC, 32'd1_000_000_000);
    send_item(uad_pkg::CMD_HEX_LOWER, 32'h0000_000F);
    send_item(uad_pkg::CMD_HEX_LOWER, 32'h0000_0010);
    send_item(uad_pkg::CMD_HEX_LOWER, 32'hABCD_EF12);
    send_item(uad_pkg::CMD_HEX_UPPER, 32'hDEAD_BEEF);
    send_item(uad_pkg::CMD_HEX_LOWER, 32'h0FED_CBA9);
    send_item(uad_pkg::CMD_HEX_UPPER, 32'h8000_0000);
    send_random(130);

    gap_pct = 53;
    stall_pct = 20;
    send_random(130);

    gap_pct = 0;
    stall_pct = 0;
    send_random(128);
    in_valid <= 1'b0;

    @(posedge clk);
    while (chars_outstanding != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[unsigned_to_ascii_digits] OK");
    end else begin
      $display("[unsigned_to_ascii_digits] ERROR");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("timeout with %0d characters outstanding", chars_outstanding);
    $display("[unsigned_to_ascii_digits] ERROR");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/uad_pkg.sv
hdl/unsigned_to_ascii_digits.sv
tb/sv/ascii_run_checker.sv
tb/sv/tb_unsigned_to_ascii_digits.sv
